[rtl/core/isotp_rx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isotp_rx_pkg
// shared types, widths and codes of the iso-tp receive reassembler
// ----------------------------------------------------------------------------
package isotp_rx_pkg;

  localparam int unsigned IdW      = 29;
  localparam int unsigned DlcW     = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 12;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 29;
  localparam int unsigned FrameCntW = 10;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD      = 2'd0,
    KIND_FLOW_CONTROL = 2'd1,
    KIND_CF_IDLE      = 2'd2,
    KIND_BAD_SEQ      = 2'd3
  } kind_t;

  // protocol control information, high nibble of byte0
  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_RECEIVE_ID   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REPLY_ID     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_FRAMES = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_GAP_CODE = 2'd3;

  localparam logic [DlcW-1:0] MaxDlc = 4'd8;
  localparam logic [2:0]      FirstFrameBytes = 3'd6;
  localparam logic [3:0]      ConsecutiveStride = 4'd7;

endpackage

`default_nettype wire

[rtl/core/isotp_rx_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isotp_rx_cfg_if
// register write channel: index and data with valid / ready
// ----------------------------------------------------------------------------
interface isotp_rx_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [isotp_rx_pkg::CfgIdxW-1:0]    index;
  logic [isotp_rx_pkg::CfgDataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/isotp_rx_frame_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isotp_rx_frame_if
// received can frame channel with valid / ready
// ----------------------------------------------------------------------------
interface isotp_rx_frame_if;
  logic                              valid;
  logic                              ready;
  logic [isotp_rx_pkg::IdW-1:0]      frame_id;
  logic [isotp_rx_pkg::DlcW-1:0]     frame_len;
  logic [isotp_rx_pkg::ByteW-1:0]    byte0;
  logic [isotp_rx_pkg::ByteW-1:0]    byte1;
  logic [isotp_rx_pkg::ByteW-1:0]    byte2;
  logic [isotp_rx_pkg::ByteW-1:0]    byte3;
  logic [isotp_rx_pkg::ByteW-1:0]    byte4;
  logic [isotp_rx_pkg::ByteW-1:0]    byte5;
  logic [isotp_rx_pkg::ByteW-1:0]    byte6;
  logic [isotp_rx_pkg::ByteW-1:0]    byte7;

  modport source (output valid, frame_id, frame_len, byte0, byte1, byte2, byte3,
                  byte4, byte5, byte6, byte7, input ready);
  modport sink   (input valid, frame_id, frame_len, byte0, byte1, byte2, byte3,
                  byte4, byte5, byte6, byte7, output ready);
endinterface

`default_nettype wire

[rtl/core/isotp_rx_result_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isotp_rx_result_if
// reassembled result channel with valid / ready
// ----------------------------------------------------------------------------
interface isotp_rx_result_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [isotp_rx_pkg::IdW-1:0]      out_id;
  logic [isotp_rx_pkg::ByteW-1:0]    payload_byte;
  logic [isotp_rx_pkg::LenW-1:0]     byte_pos;
  logic [isotp_rx_pkg::LenW-1:0]     total_len;
  logic                              msg_done;
  logic                              last;

  modport source (output valid, kind, out_id, payload_byte, byte_pos, total_len,
                  msg_done, last, input ready);
  modport sink   (input valid, kind, out_id, payload_byte, byte_pos, total_len,
                  msg_done, last, output ready);
endinterface

`default_nettype wire

[rtl/core/isotp_receive_reassembler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// isotp_receive_reassembler
// iso-tp receive side for one channel, streams payload bytes out one by one
// ----------------------------------------------------------------------------
// usage
//   cfg      : register writes (receive id, reply id, block size, st code),
//              always ready, to be written only while the block is idle
//   frames   : received can frames; a request is taken into an input register
//   results  : each result is a payload byte, flow-control request,
//              consecutive frame while idle, or bad sequence
// timing
//   a frame sits in the input register until the result register is free,
//   then it is decoded: the receive state is updated and a batch
//   descriptor (up to seven bytes plus one trailing request) is loaded
//   the first result shows once the batch is in the result register;
//   results then leave at one per cycle while results.ready holds
//   a frame occupies the result register until all of its results (1 to 8)
//   have left; frames with no result leave the result register empty
//   the next frame is taken while the current batch drains
// reset
//   rst clears configuration, receive state and both registers
// stall
//   with results.ready low the batch holds; one further frame is buffered,
//   then frames.ready drops
// ----------------------------------------------------------------------------
module isotp_receive_reassembler (
  input  wire                      clk,
  input  wire                      rst,
  isotp_rx_cfg_if.sink             cfg,
  isotp_rx_frame_if.sink           frames,
  isotp_rx_result_if.source        results
);

  // configuration registers
  logic [isotp_rx_pkg::IdW-1:0]   receive_id;
  logic [isotp_rx_pkg::IdW-1:0]   reply_id;
  logic [7:0]                     block_frames;
  logic [7:0]                     min_gap_code;

  // receive state
  logic                                 receiving;
  logic [isotp_rx_pkg::FrameCntW-1:0]   frame_count;
  logic [7:0]                           frames_left;
  logic [isotp_rx_pkg::LenW-1:0]        message_len;

  // input register
  logic                                 in_full;
  logic [isotp_rx_pkg::IdW-1:0]         in_id;
  logic [isotp_rx_pkg::DlcW-1:0]        in_dlc;
  logic [7:0]                           in_d [8];

  // result register: batch descriptor plus drain index
  logic                                 em_valid;
  logic [7:0]                           em_data [7];
  logic                                 em_offset;
  logic [2:0]                           em_nbytes;
  logic                                 em_trail;
  isotp_rx_pkg::kind_t                  em_trail_kind;
  logic [isotp_rx_pkg::LenW-1:0]        em_base;
  logic [isotp_rx_pkg::LenW-1:0]        em_total;
  logic [2:0]                           em_idx;

  logic em_last;
  logic out_fire;
  logic load;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_id   <= '0;
      reply_id     <= '0;
      block_frames <= '0;
      min_gap_code <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        isotp_rx_pkg::REG_RECEIVE_ID:   receive_id   <= cfg.data;
        isotp_rx_pkg::REG_REPLY_ID:     reply_id     <= cfg.data;
        isotp_rx_pkg::REG_BLOCK_FRAMES: block_frames <= cfg.data[7:0];
        isotp_rx_pkg::REG_MIN_GAP_CODE: min_gap_code <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign out_fire     = results.valid && results.ready;
  // decode when a frame waits and the result register is empty or emptying
  assign load         = in_full && (!em_valid || (out_fire && em_last));
  assign frames.ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (frames.valid && frames.ready) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frames.valid && frames.ready) begin
      in_id   <= frames.frame_id;
      in_dlc  <= frames.frame_len;
      in_d[0] <= frames.byte0;
      in_d[1] <= frames.byte1;
      in_d[2] <= frames.byte2;
      in_d[3] <= frames.byte3;
      in_d[4] <= frames.byte4;
      in_d[5] <= frames.byte5;
      in_d[6] <= frames.byte6;
      in_d[7] <= frames.byte7;
    end
  end

  // ---------------------------------------------------------------------------
  // frame decode
  // ---------------------------------------------------------------------------
  logic [isotp_rx_pkg::DlcW-1:0]        dlc;
  logic [2:0]                           data_cnt;
  logic [3:0]                           pci;
  logic [isotp_rx_pkg::LenW-1:0]        ff_len;
  logic [isotp_rx_pkg::FrameCntW-1:0]   fc_inc;
  logic [12:0]                          cf_start;
  logic [12:0]                          cf_room;
  logic                                 cf_past_end;
  logic                                 cf_ends;
  logic [7:0]                           fl_dec;

  logic [2:0]                           d_nbytes;
  logic                                 d_offset;
  logic                                 d_trail;
  isotp_rx_pkg::kind_t                  d_trail_kind;
  logic [isotp_rx_pkg::LenW-1:0]        d_base;
  logic [isotp_rx_pkg::LenW-1:0]        d_total;

  logic                                 receiving_next;
  logic [isotp_rx_pkg::FrameCntW-1:0]   frame_count_next;
  logic [7:0]                           frames_left_next;
  logic [isotp_rx_pkg::LenW-1:0]        message_len_next;

  always_comb begin
    // long length codes count as eight
    dlc      = (in_dlc > isotp_rx_pkg::MaxDlc) ? isotp_rx_pkg::MaxDlc : in_dlc;
    data_cnt = (dlc == '0) ? 3'd0 : 3'(dlc - 4'd1);
    pci      = in_d[0][7:4];
    ff_len   = {in_d[0][3:0], in_d[1]};

    fc_inc   = frame_count + 10'd1;
    // first byte position of this consecutive frame: 7 * (frame count + 1) - 1
    cf_start = {fc_inc, 3'b000} - {3'b000, fc_inc} - 13'd1;
    cf_past_end = cf_start >= {1'b0, message_len};
    cf_room  = {1'b0, message_len} - cf_start;
    cf_ends  = ({1'b0, cf_start} + 14'(isotp_rx_pkg::ConsecutiveStride))
               >= {2'b00, message_len};
    fl_dec   = (block_frames != '0) ? frames_left - 8'd1 : frames_left;

    d_nbytes     = '0;
    d_offset     = 1'b0;
    d_trail      = 1'b0;
    d_trail_kind = isotp_rx_pkg::KIND_FLOW_CONTROL;
    d_base       = '0;
    d_total      = '0;

    receiving_next   = receiving;
    frame_count_next = frame_count;
    frames_left_next = frames_left;
    message_len_next = message_len;

    if (in_id == receive_id) begin
      case (pci)
        isotp_rx_pkg::PCI_SINGLE: begin
          d_nbytes = data_cnt;
          d_total  = isotp_rx_pkg::LenW'(data_cnt);
        end
        isotp_rx_pkg::PCI_FIRST: begin
          d_nbytes = (ff_len < isotp_rx_pkg::LenW'(isotp_rx_pkg::FirstFrameBytes))
                     ? ff_len[2:0] : isotp_rx_pkg::FirstFrameBytes;
          d_offset = 1'b1;
          d_trail  = 1'b1;
          d_total  = ff_len;
          // a first frame always restarts the message
          receiving_next   = 1'b1;
          frame_count_next = '0;
          frames_left_next = block_frames;
          message_len_next = ff_len;
        end
        isotp_rx_pkg::PCI_CONSECUTIVE: begin
          if (!receiving) begin
            d_trail      = 1'b1;
            d_trail_kind = isotp_rx_pkg::KIND_CF_IDLE;
          end else if (fc_inc[3:0] != in_d[0][3:0]) begin
            d_trail          = 1'b1;
            d_trail_kind     = isotp_rx_pkg::KIND_BAD_SEQ;
            receiving_next   = 1'b0;
            frame_count_next = '0;
          end else begin
            // bytes past the message end are dropped
            if (cf_past_end) begin
              d_nbytes = '0;
            end else if (cf_room < 13'(data_cnt)) begin
              d_nbytes = cf_room[2:0];
            end else begin
              d_nbytes = data_cnt;
            end
            d_base           = cf_start[isotp_rx_pkg::LenW-1:0];
            d_total          = message_len;
            frame_count_next = fc_inc;
            frames_left_next = fl_dec;
            if (cf_ends) begin
              receiving_next   = 1'b0;
              frame_count_next = '0;
              message_len_next = '0;
            end else if (block_frames != '0 && fl_dec == '0) begin
              // block complete, ask the sender for the next one
              d_trail          = 1'b1;
              frames_left_next = block_frames;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving   <= 1'b0;
      frame_count <= '0;
      frames_left <= '0;
      message_len <= '0;
    end else if (load) begin
      receiving   <= receiving_next;
      frame_count <= frame_count_next;
      frames_left <= frames_left_next;
      message_len <= message_len_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register and drain
  // ---------------------------------------------------------------------------
  assign em_last = em_trail ? (em_idx == em_nbytes) : (em_idx == em_nbytes - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_idx   <= '0;
    end else if (load) begin
      // frames with nothing to report leave the register empty
      em_valid <= (d_nbytes != '0) || d_trail;
      em_idx   <= '0;
    end else if (out_fire) begin
      if (em_last) begin
        em_valid <= 1'b0;
      end
      em_idx <= em_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 7; i++) begin
        em_data[i] <= in_d[i+1];
      end
      em_offset     <= d_offset;
      em_nbytes     <= d_nbytes;
      em_trail      <= d_trail;
      em_trail_kind <= d_trail_kind;
      em_base       <= d_base;
      em_total      <= d_total;
    end
  end

  // ---------------------------------------------------------------------------
  // result fields
  // ---------------------------------------------------------------------------
  logic                           is_byte;
  logic [2:0]                     sel;
  logic [isotp_rx_pkg::LenW-1:0]  pos;

  always_comb begin
    is_byte = em_idx < em_nbytes;
    sel     = em_idx + {2'b00, em_offset};
    pos     = em_base + isotp_rx_pkg::LenW'(em_idx);

    results.valid        = em_valid;
    results.last         = em_last;
    results.kind         = is_byte ? isotp_rx_pkg::KIND_PAYLOAD : em_trail_kind;
    results.out_id       = (!is_byte && em_trail_kind == isotp_rx_pkg::KIND_FLOW_CONTROL)
                           ? reply_id : receive_id;
    results.payload_byte = is_byte ? em_data[sel] : '0;
    results.byte_pos     = is_byte ? pos : '0;
    // errors report no length
    results.total_len    = (is_byte || em_trail_kind == isotp_rx_pkg::KIND_FLOW_CONTROL)
                           ? em_total : '0;
    results.msg_done     = is_byte && ({1'b0, pos} + 13'd1 == {1'b0, em_total});
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // idle receiver keeps no frame count
  a_idle_count : assert property (@(posedge clk) disable iff (rst)
    !receiving |-> frame_count == '0)
    else $error("frame count set while not receiving");

  // drain index never runs past the batch
  a_idx_bound : assert property (@(posedge clk) disable iff (rst)
    em_valid |-> (em_idx < em_nbytes) || (em_trail && em_idx == em_nbytes))
    else $error("result index beyond batch");

  // a held frame stays until it is decoded
  a_in_hold : assert property (@(posedge clk) disable iff (rst)
    in_full && !load |=> in_full)
    else $error("buffered frame lost");

  // no batch is ever loaded empty
  a_no_empty : assert property (@(posedge clk) disable iff (rst)
    em_valid |-> (em_nbytes != '0) || em_trail)
    else $error("empty batch in result register");

  // separation time code changes only on a register write
  a_gap_stable : assert property (@(posedge clk) disable iff (rst)
    !cfg.valid |=> min_gap_code == $past(min_gap_code))
    else $error("separation time code changed without a write");

endmodule

`default_nettype wire
